// ===== design/nearest_marked_run_tracker_defines.svh =====
// Assertion macros shared by the checker of the nearest marked run tracker.
`ifndef NEAREST_MARKED_RUN_TRACKER_DEFINES_SVH
`define NEAREST_MARKED_RUN_TRACKER_DEFINES_SVH

// Clocked assertion, off while reset is asserted.
`define NMRT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Same, but also checked during reset.
`define NMRT_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== design/nmrt_pkg.sv =====
// Shared types, codes and helpers of the nearest marked run tracker.
package nmrt_pkg;

  localparam int MAX_POSITIONS_DEF = 1024;
  localparam int STACK_DEPTH_DEF   = 1024;
  localparam int POS_W             = 11;
  localparam int WORD_W            = 32;
  localparam int BIT_W             = 5;
  localparam logic [POS_W-1:0] CFG_RESET = 11'd1024;

  typedef enum logic [1:0] {
    OP_MARK   = 2'd0,
    OP_UNMARK = 2'd1,
    OP_QUERY  = 2'd2,
    OP_NONE   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2,
    ST_RANGE = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_POP,
    S_UPD,
    S_QW,
    S_QU,
    S_QD,
    S_FIN,
    S_DONE
  } state_e;

  typedef struct packed {
    logic rd;
    logic wr;
  } bm_ctl_t;

  typedef struct packed {
    logic             found;
    logic [BIT_W-1:0] idx;
  } hit_t;

  // lowest set bit of a word
  function automatic hit_t lsb_find(input logic [WORD_W-1:0] v);
    hit_t h;
    h = '0;
    for (int j = WORD_W - 1; j >= 0; j--) begin
      if (v[j]) begin
        h.found = 1'b1;
        h.idx   = BIT_W'(j);
      end
    end
    return h;
  endfunction

  // highest set bit of a word
  function automatic hit_t msb_find(input logic [WORD_W-1:0] v);
    hit_t h;
    h = '0;
    for (int j = 0; j < WORD_W; j++) begin
      if (v[j]) begin
        h.found = 1'b1;
        h.idx   = BIT_W'(j);
      end
    end
    return h;
  endfunction

endpackage

// ===== design/nmrt_bitmap.sv =====
// Mark bitmap: word memory plus a per-word nonempty summary register.
module nmrt_bitmap import nmrt_pkg::*; #(
  parameter int WA = 6
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  bm_ctl_t               ctl_i,
  input  logic [WA-1:0]         raddr_i,
  input  logic [WA-1:0]         waddr_i,
  input  logic [WORD_W-1:0]     wdata_i,
  output logic [WORD_W-1:0]     rdata_o,
  output logic [(1<<WA)-1:0]    nonempty_o
);

  logic [WORD_W-1:0]  mem [1<<WA];
  logic [WORD_W-1:0]  raw_q;
  logic               live_q;
  logic [(1<<WA)-1:0] sum_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.wr) begin
      mem[waddr_i] <= wdata_i;
    end
    if (ctl_i.rd) begin
      raw_q <= mem[raddr_i];
    end
  end

  // an empty summary bit means the word was never written or is all clear
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q  <= '0;
      live_q <= 1'b0;
    end else begin
      if (ctl_i.wr) begin
        sum_q[waddr_i] <= (wdata_i != '0);
      end
      if (ctl_i.rd) begin
        live_q <= sum_q[raddr_i];
      end
    end
  end

  assign rdata_o    = live_q ? raw_q : '0;
  assign nonempty_o = sum_q;

endmodule

// ===== design/nmrt_stack.sv =====
// Undo stack storage: one write and one registered read port.
module nmrt_stack import nmrt_pkg::*; #(
  parameter int DEPTH = STACK_DEPTH_DEF
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [POS_W-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [POS_W-1:0]         rdata_o
);

  logic [POS_W-1:0] mem [DEPTH];
  logic [POS_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/nearest_marked_run_tracker.sv =====
// Top level of the nearest marked run tracker: sequencer, stack pointer, result register.
//
//  channel | direction | handshake                   | payload
//  in      | input     | in_valid_i / in_stall_o     | op_i, position_i
//  out     | output    | out_valid_o / out_stall_i   | run_length_o, status_o
//  cfg     | input     | cfg_we_i (no wait)          | cfg_data_i (num_positions)
//
// One item at a time. Errors go straight to S_DONE; mark reads and rewrites its bitmap word
// (S_UPD), unmark pops the stack first (S_POP), and a query searches (S_QW, S_QU, S_QD, S_FIN).
// Reset clears the summary register, so the bitmap reads all clear with no
// clearing pass; the block is ready in the first cycle after reset.
// A finished result waits in the output register while the next item enters;
// a stalled output holds the sequencer in its last state until taken.
module nearest_marked_run_tracker import nmrt_pkg::*; #(
  parameter int MAX_POSITIONS = MAX_POSITIONS_DEF,
  parameter int STACK_DEPTH   = STACK_DEPTH_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [POS_W-1:0] cfg_data_i,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [1:0]       op_i,
  input  logic [POS_W-1:0] position_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [POS_W-1:0] run_length_o,
  output logic [1:0]       status_o
);

  // Bit index in the bitmap is the position itself; word = upper bits.
  localparam int PW    = ($clog2(MAX_POSITIONS + 2) < 6) ? 6 : $clog2(MAX_POSITIONS + 2);
  localparam int WA    = PW - BIT_W;
  localparam int WORDS = 1 << WA;
  localparam int SA    = $clog2(STACK_DEPTH);
  localparam int CW    = $clog2(STACK_DEPTH + 1);

  state_e            state_q, state_d;
  op_e               op_q, op_d;
  logic [PW-1:0]     pos_q, pos_d;
  logic [PW-1:0]     above_q, above_d;
  logic [PW-1:0]     below_q, below_d;
  logic [PW-1:0]     run_q, run_d;
  status_e           st_q, st_d;
  logic [CW-1:0]     cnt_q, cnt_d;
  logic [POS_W-1:0]  cfg_q;
  logic              oval_q, oval_d;
  logic [POS_W-1:0]  orun_q, orun_d;
  status_e           ost_q, ost_d;

  logic [PW-1:0]     n_eff, n_p1;
  logic              accept, pos_ok;
  logic [PW-1:0]     pos_in, pop_pos;

  bm_ctl_t           bm_ctl;
  logic [WA-1:0]     bm_raddr, bm_waddr;
  logic [WORD_W-1:0] bm_wdata, bm_rdata;
  logic [WORDS-1:0]  nonempty;

  logic              stk_we, stk_re;
  logic [SA-1:0]     stk_waddr, stk_raddr;
  logic [POS_W-1:0]  stk_rdata;

  logic [WA-1:0]     w_cur, nu, nd;
  logic              nu_hit, nd_hit;
  logic [WORD_W-1:0] up_mask, dn_mask, nu_mask, bit_sel;
  hit_t              up_hit, dn_hit, nup_hit, ndn_hit;

  // configuration and effective N (clamped to 1..MAX_POSITIONS)
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
    end else if (cfg_we_i) begin
      cfg_q <= cfg_data_i;
    end
  end

  always_comb begin
    if (cfg_q == '0) begin
      n_eff = PW'(1);
    end else if (32'(cfg_q) > MAX_POSITIONS) begin
      n_eff = PW'(MAX_POSITIONS);
    end else begin
      n_eff = PW'(32'(cfg_q));
    end
  end
  assign n_p1 = n_eff + PW'(1);

  assign in_stall_o = (state_q != S_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign pos_ok     = (position_i != '0) && (32'(position_i) <= 32'(n_eff));
  assign pos_in     = PW'(32'(position_i));
  assign pop_pos    = PW'(32'(stk_rdata));
  assign w_cur      = pos_q[PW-1:BIT_W];

  // in-word masks and nearest nonempty neighbor words
  always_comb begin
    logic [PW-1:0] idx;
    for (int j = 0; j < WORD_W; j++) begin
      idx        = {pos_q[PW-1:BIT_W], BIT_W'(j)};
      up_mask[j] = (BIT_W'(j) >= pos_q[BIT_W-1:0]) && (idx <= n_eff);
      dn_mask[j] = (BIT_W'(j) <= pos_q[BIT_W-1:0]);
      idx        = {nu, BIT_W'(j)};
      nu_mask[j] = (idx <= n_eff);
      bit_sel[j] = (BIT_W'(j) == pos_q[BIT_W-1:0]);
    end
    nu_hit = 1'b0;
    nu     = '0;
    for (int k = WORDS - 1; k >= 0; k--) begin
      if (nonempty[k] && (WA'(k) > w_cur)) begin
        nu_hit = 1'b1;
        nu     = WA'(k);
      end
    end
    nd_hit = 1'b0;
    nd     = '0;
    for (int k = 0; k < WORDS; k++) begin
      if (nonempty[k] && (WA'(k) < w_cur)) begin
        nd_hit = 1'b1;
        nd     = WA'(k);
      end
    end
  end

  assign up_hit  = lsb_find(bm_rdata & up_mask);
  assign dn_hit  = msb_find(bm_rdata & dn_mask);
  assign nup_hit = lsb_find(bm_rdata & nu_mask);
  assign ndn_hit = msb_find(bm_rdata);

  // sequencer
  always_comb begin
    state_d   = state_q;
    op_d      = op_q;
    pos_d     = pos_q;
    above_d   = above_q;
    below_d   = below_q;
    run_d     = run_q;
    st_d      = st_q;
    cnt_d     = cnt_q;
    oval_d    = oval_q && out_stall_i;
    orun_d    = orun_q;
    ost_d     = ost_q;
    bm_ctl    = '0;
    bm_raddr  = w_cur;
    bm_waddr  = w_cur;
    bm_wdata  = bm_rdata;
    stk_we    = 1'b0;
    stk_re    = 1'b0;
    stk_waddr = cnt_q[SA-1:0];
    stk_raddr = SA'(cnt_q - CW'(1));

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          op_d    = op_e'(op_i);
          pos_d   = pos_in;
          run_d   = '0;
          st_d    = ST_OK;
          state_d = S_DONE;
          unique case (op_e'(op_i))
            OP_MARK: begin
              if (!pos_ok) begin
                st_d = ST_RANGE;
              end else if (cnt_q == CW'(STACK_DEPTH)) begin
                st_d = ST_FULL;
              end else begin
                stk_we    = 1'b1;
                cnt_d     = cnt_q + CW'(1);
                bm_ctl.rd = 1'b1;
                bm_raddr  = pos_in[PW-1:BIT_W];
                state_d   = S_UPD;
              end
            end
            OP_UNMARK: begin
              if (cnt_q == '0) begin
                st_d = ST_EMPTY;
              end else begin
                stk_re  = 1'b1;
                cnt_d   = cnt_q - CW'(1);
                state_d = S_POP;
              end
            end
            OP_QUERY: begin
              if (!pos_ok) begin
                st_d = ST_RANGE;
              end else begin
                bm_ctl.rd = 1'b1;
                bm_raddr  = pos_in[PW-1:BIT_W];
                state_d   = S_QW;
              end
            end
            OP_NONE: begin
            end
            default: begin
            end
          endcase
        end
      end
      S_POP: begin
        pos_d     = pop_pos;
        bm_ctl.rd = 1'b1;
        bm_raddr  = pop_pos[PW-1:BIT_W];
        state_d   = S_UPD;
      end
      S_UPD: begin
        bm_ctl.wr = 1'b1;
        bm_wdata  = (op_q == OP_MARK) ? (bm_rdata | bit_sel) : (bm_rdata & ~bit_sel);
        state_d   = S_DONE;
      end
      S_QW: begin
        above_d = up_hit.found ? {w_cur, up_hit.idx} : n_p1;
        below_d = dn_hit.found ? {w_cur, dn_hit.idx} : '0;
        if (!up_hit.found && nu_hit) begin
          bm_ctl.rd = 1'b1;
          bm_raddr  = nu;
          state_d   = S_QU;
        end else if (!dn_hit.found && nd_hit) begin
          bm_ctl.rd = 1'b1;
          bm_raddr  = nd;
          state_d   = S_QD;
        end else begin
          state_d = S_FIN;
        end
      end
      S_QU: begin
        above_d = nup_hit.found ? {nu, nup_hit.idx} : n_p1;
        if (below_q == '0 && nd_hit) begin
          bm_ctl.rd = 1'b1;
          bm_raddr  = nd;
          state_d   = S_QD;
        end else begin
          state_d = S_FIN;
        end
      end
      S_QD: begin
        below_d = ndn_hit.found ? {nd, ndn_hit.idx} : '0;
        state_d = S_FIN;
      end
      S_FIN: begin
        run_d   = (above_q > below_q + PW'(1)) ? (above_q - below_q - PW'(1)) : '0;
        state_d = S_DONE;
      end
      S_DONE: begin
        if (!oval_q || !out_stall_i) begin
          oval_d  = 1'b1;
          orun_d  = POS_W'(run_q);
          ost_d   = st_q;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      oval_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      oval_q  <= oval_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q    <= op_d;
    pos_q   <= pos_d;
    above_q <= above_d;
    below_q <= below_d;
    run_q   <= run_d;
    st_q    <= st_d;
    orun_q  <= orun_d;
    ost_q   <= ost_d;
  end

  assign out_valid_o  = oval_q;
  assign run_length_o = orun_q;
  assign status_o     = ost_q;

  nmrt_bitmap #(
    .WA(WA)
  ) u_bitmap (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (bm_ctl),
    .raddr_i    (bm_raddr),
    .waddr_i    (bm_waddr),
    .wdata_i    (bm_wdata),
    .rdata_o    (bm_rdata),
    .nonempty_o (nonempty)
  );

  nmrt_stack #(
    .DEPTH(STACK_DEPTH)
  ) u_stack (
    .clk_i   (clk_i),
    .we_i    (stk_we),
    .waddr_i (stk_waddr),
    .wdata_i (position_i),
    .re_i    (stk_re),
    .raddr_i (stk_raddr),
    .rdata_o (stk_rdata)
  );

endmodule

// ===== design/nmrt_checker.sv =====
// Port-level checker of the nearest marked run tracker, bound to the top level.
`include "nearest_marked_run_tracker_defines.svh"

module nmrt_checker import nmrt_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid_i,
  input logic             in_stall_o,
  input logic             out_valid_o,
  input logic             out_stall_i,
  input logic [POS_W-1:0] run_length_o,
  input logic [1:0]       status_o
);

  `NMRT_ASSERT(a_out_hold, out_valid_o && out_stall_i |=> out_valid_o, "result dropped while stalled")
  `NMRT_ASSERT(a_one_item, in_valid_i && !in_stall_o |=> in_stall_o, "second item taken while busy")
  `NMRT_ASSERT(a_err_zero, out_valid_o && status_o != ST_OK |-> run_length_o == '0, "error result with nonzero run")
  `NMRT_ASSERT_ALWAYS(a_rst_idle, !rst_ni |-> !out_valid_o, "result shown in reset")

endmodule

bind nearest_marked_run_tracker nmrt_checker u_nmrt_checker (.*);
